FILE: rtl/trs_pkg.sv
// Shared types and constants for the TRS to affine matrix pipeline.
// No dependencies.
package trs_pkg;

  localparam int QW         = 32;
  localparam int MagW       = 63;
  localparam int QuotW      = 18;
  localparam int RotW       = 18;
  localparam int NumLanes   = 9;
  localparam int DivSteps   = QuotW;
  localparam int FrontStg   = 4;
  localparam int ScaleStg   = 3;
  localparam int NumStages  = FrontStg + DivSteps + ScaleStg;
  localparam int InW        = 10 * QW;
  localparam int OutW       = 4 * QW;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_ZERO_SCALE = 2'd1;
  localparam logic [1:0] ST_ZERO_QUAT  = 2'd2;

  localparam logic [QW-1:0] ONE_Q16 = 32'h0001_0000;

  typedef logic signed [QW-1:0] q16_t;

  typedef struct packed {
    q16_t [2:0] trans;
    q16_t [2:0] scale;
    logic [1:0] status;
  } side_t;

endpackage

FILE: rtl/trs_front.sv
// Front stages: quaternion range halving, products, numerator sums, magnitudes.
// Depends on trs_pkg.
module trs_front (
  input  logic                                                  clk,
  input  logic                                                  en,
  input  trs_pkg::q16_t [3:0]                                   quat,
  output logic [trs_pkg::MagW-1:0]                              den,
  output logic [trs_pkg::NumLanes-1:0][trs_pkg::MagW-1:0]       num_mag,
  output logic [trs_pkg::NumLanes-1:0]                          num_neg
);
  import trs_pkg::*;

  logic                  big;
  q16_t [3:0]            qh_next;
  q16_t [3:0]            qh;
  logic signed [63:0]    xx, yy, zz, ww, xy, xz, yz, xw, yw, zw;
  logic signed [63:0]    n2;
  logic signed [63:0]    num [NumLanes];

  always_comb begin
    big = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (quat[i] > 32'sd1073741824 || quat[i] < -32'sd1073741824) big = 1'b1;
    end
    for (int i = 0; i < 4; i++) begin
      qh_next[i] = big ? ((quat[i] + $signed({31'd0, quat[i][QW-1]})) >>> 1) : quat[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qh <= qh_next;
      xx <= qh[0] * qh[0];
      yy <= qh[1] * qh[1];
      zz <= qh[2] * qh[2];
      ww <= qh[3] * qh[3];
      xy <= qh[0] * qh[1];
      xz <= qh[0] * qh[2];
      yz <= qh[1] * qh[2];
      xw <= qh[0] * qh[3];
      yw <= qh[1] * qh[3];
      zw <= qh[2] * qh[3];
      // column-major lanes: lane = col*3 + row
      n2     <= xx + yy + zz + ww;
      num[0] <= ww + xx - yy - zz;
      num[1] <= (xy + zw) <<< 1;
      num[2] <= (xz - yw) <<< 1;
      num[3] <= (xy - zw) <<< 1;
      num[4] <= ww + yy - xx - zz;
      num[5] <= (yz + xw) <<< 1;
      num[6] <= (xz + yw) <<< 1;
      num[7] <= (yz - xw) <<< 1;
      num[8] <= ww + zz - xx - yy;
      den <= n2[MagW-1:0];
      for (int i = 0; i < NumLanes; i++) begin
        num_neg[i] <= num[i][63];
        num_mag[i] <= num[i][63] ? MagW'(-num[i]) : num[i][MagW-1:0];
      end
    end
  end

endmodule

FILE: rtl/trs_div.sv
// Restoring divider pipeline, one quotient bit per stage, nine lanes sharing a divisor.
// Depends on trs_pkg.
module trs_div (
  input  logic                                                  clk,
  input  logic                                                  en,
  input  logic [trs_pkg::MagW-1:0]                              den,
  input  logic [trs_pkg::NumLanes-1:0][trs_pkg::MagW-1:0]       num_mag,
  input  logic [trs_pkg::NumLanes-1:0]                          num_neg,
  output logic [trs_pkg::NumLanes-1:0][trs_pkg::QuotW-1:0]      quot,
  output logic [trs_pkg::NumLanes-1:0]                          quot_neg
);
  import trs_pkg::*;

  logic [MagW-1:0]                          dd  [DivSteps];
  logic [NumLanes-1:0][MagW-1:0]            rem [DivSteps];
  logic [NumLanes-1:0][QuotW-1:0]           qb  [DivSteps];
  logic [NumLanes-1:0]                      ng  [DivSteps];

  for (genvar k = 0; k < DivSteps; k++) begin : g_step
    logic [NumLanes-1:0][MagW:0]     src;
    logic [NumLanes-1:0]             ge;
    logic [MagW-1:0]                 d_in;
    logic [NumLanes-1:0]             n_in;
    logic [NumLanes-1:0][QuotW-1:0]  q_in;

    if (k == 0) begin : g_first
      always_comb begin
        d_in = den;
        n_in = num_neg;
        q_in = '0;
        for (int i = 0; i < NumLanes; i++) src[i] = {1'b0, num_mag[i]};
      end
    end else begin : g_next
      always_comb begin
        d_in = dd[k-1];
        n_in = ng[k-1];
        q_in = qb[k-1];
        for (int i = 0; i < NumLanes; i++) src[i] = {rem[k-1][i], 1'b0};
      end
    end

    always_comb begin
      for (int i = 0; i < NumLanes; i++) begin
        ge[i] = src[i] >= {1'b0, d_in};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dd[k] <= d_in;
        ng[k] <= n_in;
        for (int i = 0; i < NumLanes; i++) begin
          rem[k][i] <= ge[i] ? MagW'(src[i] - {1'b0, d_in}) : src[i][MagW-1:0];
          qb[k][i]  <= {q_in[i][QuotW-2:0], ge[i]};
        end
      end
    end
  end

  assign quot     = qb[DivSteps-1];
  assign quot_neg = ng[DivSteps-1];

endmodule

FILE: rtl/trs_scale.sv
// Quotient rounding, per-axis scale multiply, rounding and saturation to Q16.16.
// Depends on trs_pkg.
module trs_scale (
  input  logic                                                  clk,
  input  logic                                                  en,
  input  logic [trs_pkg::NumLanes-1:0][trs_pkg::QuotW-1:0]      quot,
  input  logic [trs_pkg::NumLanes-1:0]                          quot_neg,
  input  trs_pkg::q16_t [2:0]                                   scale,
  output trs_pkg::q16_t [trs_pkg::NumLanes-1:0]                 res
);
  import trs_pkg::*;

  logic signed [RotW-1:0]       rot  [NumLanes];
  logic signed [RotW+QW-1:0]    prod [NumLanes];

  for (genvar i = 0; i < NumLanes; i++) begin : g_lane
    logic [QuotW-1:0]           rq;
    logic [RotW+QW-1:0]         mag;
    logic [RotW+QW-1:0]         rnd;
    logic [QW:0]                m;
    q16_t                       sat;

    always_comb begin
      rq  = (quot[i] + QuotW'(1)) >> 1;
      mag = prod[i][RotW+QW-1] ? (RotW+QW)'(-prod[i]) : prod[i];
      rnd = mag + (RotW+QW)'(32768);
      m   = rnd[QW+16:16];
      if (prod[i][RotW+QW-1]) begin
        sat = (m > {1'b0, 32'h8000_0000}) ? q16_t'(32'h8000_0000) : q16_t'(-m[QW-1:0]);
      end else begin
        sat = (m > {1'b0, 32'h7fff_ffff}) ? q16_t'(32'h7fff_ffff) : q16_t'(m[QW-1:0]);
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rot[i]  <= quot_neg[i] ? -$signed(rq) : $signed(rq);
        prod[i] <= rot[i] * scale[i / 3];
        res[i]  <= sat;
      end
    end
  end

endmodule

FILE: rtl/trs_col_out.sv
// Output register that sends one matrix column per transaction.
// Depends on trs_pkg.
module trs_col_out (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   vin,
  input  trs_pkg::q16_t [trs_pkg::NumLanes-1:0]  vals,
  input  trs_pkg::side_t                         side,
  output logic                                   en,
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  output logic [trs_pkg::OutW-1:0]               m_tdata,
  output logic                                   m_tlast,
  output logic [3:0]                             m_tuser
);
  import trs_pkg::*;

  logic                        busy;
  logic [1:0]                  col;
  q16_t [NumLanes-1:0]         v;
  q16_t [2:0]                  trans;
  logic [1:0]                  status;
  logic                        last_beat;

  assign last_beat = (status != ST_OK) || (col == 2'd3);
  assign en        = !busy || (m_tready && last_beat);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      col  <= 2'd0;
    end else if (en) begin
      busy <= vin;
      col  <= 2'd0;
    end else if (m_tready) begin
      col <= col + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (en && vin) begin
      v      <= vals;
      trans  <= side.trans;
      status <= side.status;
    end
  end

  always_comb begin
    m_tdata = '0;
    if (status == ST_OK) begin
      case (col)
        2'd0: m_tdata = {32'd0, v[2], v[1], v[0]};
        2'd1: m_tdata = {32'd0, v[5], v[4], v[3]};
        2'd2: m_tdata = {32'd0, v[8], v[7], v[6]};
        default: m_tdata = {ONE_Q16, trans[2], trans[1], trans[0]};
      endcase
    end
  end

  assign m_tvalid = busy;
  assign m_tlast  = last_beat;
  assign m_tuser  = {status, col};

`ifndef NO_ASSERTIONS
  a_err_single: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && status != ST_OK |-> col == 2'd0 && m_tlast)
    else $error("error result not a single column 0");
  a_col_step: assert property (@(posedge clk) disable iff (rst)
    busy && m_tready && !last_beat |=> busy && col == $past(col) + 2'd1)
    else $error("column did not advance");
  a_load: assert property (@(posedge clk) disable iff (rst)
    en && vin |=> m_tvalid && col == 2'd0)
    else $error("loaded item not presented from column 0");
`endif

endmodule

FILE: rtl/trs_to_affine_matrix.sv
// Pipeline: 25 pipeline stages (4 front, 18 divider steps, 3 scale) plus the
// output register lie between the input transaction and the first column.
// Throughput: one input per cycle into the pipeline while en is high. The output
// sends 4 columns per input (1 on error) and stalls until the last one is taken.
// Reset (rst, synchronous) clears valid bits and the output state only.
module trs_to_affine_matrix (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // trans_x, trans_y, trans_z, quat_x, quat_y, quat_z, quat_w, scale_x, scale_y, scale_z
  input  logic [trs_pkg::InW-1:0]     s_tdata,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // row0, row1, row2, row3
  output logic [trs_pkg::OutW-1:0]    m_tdata,
  output logic                        m_tlast,
  // column[1:0], status[3:2]
  output logic [3:0]                  m_tuser
);
  import trs_pkg::*;

  logic                                   en;
  q16_t [9:0]                             f;
  q16_t [3:0]                             quat;
  side_t                                  side_in;
  side_t                                  side  [NumStages];
  logic [NumStages-1:0]                   vld;
  logic [MagW-1:0]                        den;
  logic [NumLanes-1:0][MagW-1:0]          num_mag;
  logic [NumLanes-1:0]                    num_neg;
  logic [NumLanes-1:0][QuotW-1:0]         quot;
  logic [NumLanes-1:0]                    quot_neg;
  q16_t [NumLanes-1:0]                    res;

  assign f        = s_tdata;
  assign quat     = {f[6], f[5], f[4], f[3]};
  assign s_tready = en;

  always_comb begin
    side_in.trans = {f[2], f[1], f[0]};
    side_in.scale = {f[9], f[8], f[7]};
    if (f[7] == '0 || f[8] == '0 || f[9] == '0) side_in.status = ST_ZERO_SCALE;
    else if (quat == '0) side_in.status = ST_ZERO_QUAT;
    else side_in.status = ST_OK;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NumStages-2:0], s_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side[0] <= side_in;
      for (int k = 1; k < NumStages; k++) side[k] <= side[k-1];
    end
  end

  trs_front u_front (
    .clk     (clk),
    .en      (en),
    .quat    (quat),
    .den     (den),
    .num_mag (num_mag),
    .num_neg (num_neg)
  );

  trs_div u_div (
    .clk      (clk),
    .en       (en),
    .den      (den),
    .num_mag  (num_mag),
    .num_neg  (num_neg),
    .quot     (quot),
    .quot_neg (quot_neg)
  );

  trs_scale u_scale (
    .clk      (clk),
    .en       (en),
    .quot     (quot),
    .quot_neg (quot_neg),
    .scale    (side[FrontStg+DivSteps].scale),
    .res      (res)
  );

  trs_col_out u_out (
    .clk      (clk),
    .rst      (rst),
    .vin      (vld[NumStages-1]),
    .vals     (res),
    .side     (side[NumStages-1]),
    .en       (en),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule
